@@ src/generation_mailbox_two_slot_top_assert.svh @@
`ifndef GENERATION_MAILBOX_TWO_SLOT_TOP_ASSERT_SVH
`define GENERATION_MAILBOX_TWO_SLOT_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle, checked outside reset
`define GMTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequent in the next cycle, checked also across reset
`define GMTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/gmts_pkg.sv @@
package gmts_pkg;

   localparam logic [2:0] OP_OPEN   = 3'd0;
   localparam logic [2:0] OP_POST   = 3'd1;
   localparam logic [2:0] OP_CLOSE  = 3'd2;
   localparam logic [2:0] OP_QUERY  = 3'd3;
   localparam logic [2:0] OP_TAKE   = 3'd4;
   localparam logic [2:0] OP_RETIRE = 3'd5;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_REPORT = 2'd1;
   localparam logic [1:0] KIND_FRAME  = 2'd2;

   localparam logic [2:0] REASON_FAULT = 3'b100;
   localparam logic [1:0] NUM_SLOTS    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] generation;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] timestamp;
      logic [2:0]  close_reasons;
   } req_item_type;

   typedef struct packed {
      logic        ok;
      logic [1:0]  kind;
      logic [31:0] out_generation;
      logic [31:0] out_timestamp;
      logic [2:0]  out_reasons;
      logic [7:0]  out_byte;
      logic        last;
   } rsp_item_type;

endpackage

@@ src/gmts_ram.sv @@
module gmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/gmts_out.sv @@
module gmts_out
   import gmts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type q0_ff, q0_in;
   rsp_item_type q1_ff, q1_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         pop;

   assign pop       = (cnt_ff != 2'd0) && out_ready;
   assign room      = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = q0_ff;

   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            q0_in = q1_ff;
         end else if (push) begin
            q0_in = push_item;
         end
      end else if (push && (cnt_ff == 2'd0)) begin
         q0_in = push_item;
      end
      if (push && !pop && (cnt_ff == 2'd1)) begin
         q1_in = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

endmodule

@@ src/gmts_ctrl.sv @@
module gmts_ctrl
   import gmts_pkg::*;
#(
   parameter int FRAME_BYTES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         csr_valid,
   input  logic [31:0]  csr_data,
   input  logic         room,
   output logic         push,
   output rsp_item_type push_item
);

   localparam int IW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int AW = $clog2(2 * FRAME_BYTES);
   localparam logic [IW-1:0] LAST_POS = IW'(FRAME_BYTES - 1);

   state_type    state_ff, state_in;
   logic [31:0]  timeout_ff;
   logic [31:0]  gen_ff, gen_in;
   logic         open_ff, open_in;
   logic [2:0]   rb_ff, rb_in;
   logic         rep_ff, rep_in;
   logic [1:0]   fc_ff, fc_in;
   logic         head_ff, head_in;
   logic [IW-1:0] fill_ff, fill_in;
   logic [31:0]  time_ff [2];
   logic [31:0]  time_in [2];
   logic         run_slot_ff, run_slot_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0]  run_time_ff, run_time_in;

   logic         acc;
   logic         start_run;
   logic         single_push;
   logic         send_push;
   rsp_item_type single_item;
   rsp_item_type send_item;
   logic         gen_match;
   logic         tail;
   logic         mem_we;
   logic [AW-1:0] mem_waddr;
   logic         mem_re;
   logic [AW-1:0] mem_raddr;
   logic [7:0]   mem_rdata;
   logic [31:0]  age;
   logic         timed_out;

   assign acc       = req_valid && req_ready;
   assign gen_match = open_ff && (req_item.generation != 32'd0) &&
                      (gen_ff == req_item.generation);
   assign tail      = head_ff ^ fc_ff[0];
   assign mem_waddr = tail ? (AW'(FRAME_BYTES) + AW'(fill_ff)) : AW'(fill_ff);
   assign mem_raddr = run_slot_ff ? (AW'(FRAME_BYTES) + AW'(idx_ff)) : AW'(idx_ff);
   assign age       = req_item.timestamp - time_ff[head_ff];
   assign timed_out = (fc_ff != 2'd0) && (age > timeout_ff);

   gmts_ram #(
      .WIDTH (8),
      .DEPTH (2 * FRAME_BYTES)
   ) u_bytes (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (req_item.data_byte),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_run) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (room) begin
               state_in = (idx_ff == LAST_POS) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      send_push = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = room;
         ST_READ: mem_re    = 1'b1;
         ST_SEND: send_push = room;
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      send_item                = '0;
      send_item.ok             = 1'b1;
      send_item.kind           = KIND_FRAME;
      send_item.out_generation = gen_ff;
      send_item.out_timestamp  = run_time_ff;
      send_item.out_byte       = mem_rdata;
      send_item.last           = (idx_ff == LAST_POS);
   end

   assign push      = single_push || send_push;
   assign push_item = send_push ? send_item : single_item;

   // mailbox state update
   always_comb begin : mailbox_update
      logic [2:0] rb_t;
      logic       rep_t;
      logic [1:0] fc_t;
      gen_in      = gen_ff;
      open_in     = open_ff;
      rb_in       = rb_ff;
      rep_in      = rep_ff;
      fc_in       = fc_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      time_in     = time_ff;
      run_slot_in = run_slot_ff;
      idx_in      = idx_ff;
      run_time_in = run_time_ff;
      mem_we      = 1'b0;
      start_run   = 1'b0;
      single_push = 1'b0;
      single_item = '0;
      single_item.last = 1'b1;
      rb_t  = rb_ff;
      rep_t = rep_ff;
      fc_t  = fc_ff;
      if (send_push && (idx_ff != LAST_POS)) begin
         idx_in = idx_ff + IW'(1);
      end
      if (acc) begin
         single_push = 1'b1;
         unique case (req_item.opcode)
            OP_OPEN: begin
               if (!open_ff && (rb_ff == 3'd0) && !rep_ff && (fc_ff == 2'd0) &&
                   !head_ff && (req_item.generation != 32'd0) &&
                   (req_item.generation > gen_ff)) begin
                  gen_in         = req_item.generation;
                  open_in        = 1'b1;
                  fill_in        = '0;
                  single_item.ok = 1'b1;
               end
            end
            OP_POST: begin
               if (gen_match && (rb_ff == 3'd0)) begin
                  if (fc_ff >= NUM_SLOTS) begin
                     rb_in   = REASON_FAULT;
                     rep_in  = 1'b0;
                     fc_in   = 2'd0;
                     fill_in = '0;
                  end else begin
                     mem_we = 1'b1;
                     if (req_item.last_byte && (fill_ff == LAST_POS)) begin
                        time_in[tail]  = req_item.timestamp;
                        fc_in          = fc_ff + 2'd1;
                        fill_in        = '0;
                        single_item.ok = 1'b1;
                     end else if (req_item.last_byte || (fill_ff == LAST_POS)) begin
                        rb_in   = REASON_FAULT;
                        rep_in  = 1'b0;
                        fc_in   = 2'd0;
                        fill_in = '0;
                     end else begin
                        fill_in        = fill_ff + IW'(1);
                        single_item.ok = 1'b1;
                     end
                  end
               end
            end
            OP_CLOSE: begin
               if ((req_item.close_reasons != 3'd0) && gen_match) begin
                  if ((rb_ff & req_item.close_reasons) != req_item.close_reasons) begin
                     rep_in = 1'b0;
                  end
                  rb_in          = rb_ff | req_item.close_reasons;
                  fc_in          = 2'd0;
                  fill_in        = '0;
                  single_item.ok = 1'b1;
               end
            end
            OP_QUERY: begin
               single_item.ok = gen_match && (rb_ff == 3'd0);
            end
            OP_TAKE: begin
               if (timed_out) begin
                  if ((rb_ff & REASON_FAULT) != REASON_FAULT) begin
                     rep_t = 1'b0;
                  end
                  rb_t    = rb_ff | REASON_FAULT;
                  fc_t    = 2'd0;
                  fill_in = '0;
               end
               rb_in  = rb_t;
               rep_in = rep_t;
               fc_in  = fc_t;
               if ((rb_t != 3'd0) && !rep_t) begin
                  rep_in                     = 1'b1;
                  single_item.ok             = 1'b1;
                  single_item.kind           = KIND_REPORT;
                  single_item.out_generation = gen_ff;
                  single_item.out_reasons    = rb_t;
               end else if (fc_t != 2'd0) begin
                  fc_in       = fc_t - 2'd1;
                  head_in     = ~head_ff;
                  start_run   = 1'b1;
                  single_push = 1'b0;
                  run_slot_in = head_ff;
                  idx_in      = '0;
                  run_time_in = time_ff[head_ff];
               end
            end
            OP_RETIRE: begin
               if (gen_match && (rb_ff != 3'd0) && rep_ff) begin
                  open_in        = 1'b0;
                  rb_in          = 3'd0;
                  rep_in         = 1'b0;
                  fc_in          = 2'd0;
                  head_in        = 1'b0;
                  fill_in        = '0;
                  single_item.ok = 1'b1;
               end
            end
            default: begin
               single_item.ok = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         timeout_ff <= 32'd1000;
         gen_ff     <= 32'd0;
         open_ff    <= 1'b0;
         rb_ff      <= 3'd0;
         rep_ff     <= 1'b0;
         fc_ff      <= 2'd0;
         head_ff    <= 1'b0;
         fill_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         gen_ff  <= gen_in;
         open_ff <= open_in;
         rb_ff   <= rb_in;
         rep_ff  <= rep_in;
         fc_ff   <= fc_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
      time_ff     <= time_in;
      run_slot_ff <= run_slot_in;
      idx_ff      <= idx_in;
      run_time_ff <= run_time_in;
   end

endmodule

@@ src/generation_mailbox_two_slot_top.sv @@
// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | req_tdata, req_tuser, req_tlast
// rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata, rsp_tuser, rsp_tlast
// csr      | in        | csr_valid/csr_ready    | csr_data (timeout_ticks)
//
// open, post, close, query, retire and a take without a frame: accepted while idle, one result each
// take with a frame: one byte ram read and one send per byte, each send waiting for queue room
// results pass through a two-entry output queue; req_tready drops when it is full
// synchronous reset clears control state; frame bytes and slot times need no clearing
`include "generation_mailbox_two_slot_top_assert.svh"
module generation_mailbox_two_slot_top
   import gmts_pkg::*;
#(
   parameter int FRAME_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // generation, data_byte, timestamp, close_reasons
   input  logic [2:0]  req_tuser,   // opcode
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // ok, out_generation, out_timestamp, out_reasons, out_byte
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   req_item_type req_item;
   rsp_item_type push_item;
   rsp_item_type out_item;
   logic         push;
   logic         room;

   assign req_item.opcode        = req_tuser;
   assign req_item.generation    = req_tdata[31:0];
   assign req_item.data_byte     = req_tdata[39:32];
   assign req_item.last_byte     = req_tlast;
   assign req_item.timestamp     = req_tdata[71:40];
   assign req_item.close_reasons = req_tdata[74:72];

   assign csr_ready = 1'b1;

   gmts_ctrl #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .room      (room),
      .push      (push),
      .push_item (push_item)
   );

   gmts_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {4'd0, out_item.out_byte, out_item.out_reasons,
                       out_item.out_timestamp, out_item.out_generation, out_item.ok};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

   `GMTS_ASSERT_NOW(a_run_only_frames, rsp_tvalid && !rsp_tlast, rsp_tuser == KIND_FRAME, "open run that is not a frame")
   `GMTS_ASSERT_NOW(a_report_has_reasons, rsp_tvalid && (rsp_tuser == KIND_REPORT), rsp_tdata[67:65] != 3'd0, "closed report without reasons")
   `GMTS_ASSERT_NOW(a_frame_ok, rsp_tvalid && (rsp_tuser == KIND_FRAME), rsp_tdata[0] && (rsp_tdata[67:65] == 3'd0), "frame byte with bad ok or reasons")
   `GMTS_ASSERT_NEXT(a_reset_empty, reset, !rsp_tvalid, "result pending after reset")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import gmts_pkg::*;

   localparam int FRAME_BYTES = 16;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;
   localparam int PHASE_ITEMS = 40;
   localparam int DRAIN_CYCLES = 2 * FRAME_BYTES + 8;
   localparam int HOLD_CYCLES = 400;
   localparam longint LIMIT_CYCLES = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [79:0] req_tdata;
   logic [2:0] req_tuser;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [31:0] csr_data = 32'd0;

   req_item_type req_item = '0;

   // mailbox state as the block should hold it
   logic [31:0] m_timeout = 32'd1000;
   logic [31:0] m_generation = 32'd0;
   logic m_open = 1'b0;
   logic [2:0] m_reasons = 3'd0;
   logic m_reported = 1'b0;
   logic [1:0] m_frames = 2'd0;
   logic m_head = 1'b0;
   logic [6:0] m_fill = 7'd0;
   logic [7:0] m_bytes [2*FRAME_BYTES];
   logic [31:0] m_time [2] = '{32'd0, 32'd0};

   rsp_item_type mailbox_results_q [$];
   req_item_type request_q [$];

   int error_count = 0;
   int requests_accepted = 0;
   int queued_count = 0;
   int req_gap = 0;
   int rsp_wait = 0;
   int calm_left = 0;
   longint cycle_count = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit rsp_hold = 1'b0;
   logic [31:0] session_gen = 32'd0;
   logic [31:0] clock_now = 32'd0;

   generation_mailbox_two_slot_top #(
      .FRAME_BYTES(FRAME_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   assign req_tdata = {5'd0, req_item.close_reasons, req_item.timestamp, req_item.data_byte,
                       req_item.generation};
   assign req_tuser = req_item.opcode;
   assign req_tlast = req_item.last_byte;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_error(input string what, input logic [31:0] seen, input logic [31:0] want);
      if (error_count < 100)
         $display("mismatch %0s: got %0h want %0h", what, seen, want);
      error_count++;
   endtask

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (calm_left > 0 || r < 50)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void mailbox_shut(input logic [2:0] why);
      if ((m_reasons & why) != why)
         m_reported = 1'b0;
      m_reasons = m_reasons | why;
      m_frames = 2'd0;
      m_fill = 7'd0;
   endfunction

   function automatic void mailbox_step(input req_item_type r);
      logic ok;
      logic hit;
      logic done;
      logic tail;
      logic h;
      logic [31:0] age;
      int p;
      rsp_item_type res;
      ok = 1'b0;
      done = 1'b0;
      res = '0;
      res.last = 1'b1;
      hit = m_open && r.generation != 32'd0 && m_generation == r.generation;
      case (r.opcode)
         OP_OPEN: begin
            if (!m_open && m_reasons == 3'd0 && !m_reported && m_frames == 2'd0 && !m_head &&
                r.generation != 32'd0 && r.generation > m_generation) begin
               m_generation = r.generation;
               m_open = 1'b1;
               m_fill = 7'd0;
               ok = 1'b1;
            end
         end
         OP_POST: begin
            if (hit && m_reasons == 3'd0) begin
               p = m_fill;
               if (m_frames >= NUM_SLOTS || p >= FRAME_BYTES) begin
                  mailbox_shut(REASON_FAULT);
               end else begin
                  tail = m_head ^ m_frames[0];
                  m_bytes[tail * FRAME_BYTES + p] = r.data_byte;
                  if (r.last_byte) begin
                     if (p == FRAME_BYTES - 1) begin
                        m_time[tail] = r.timestamp;
                        m_frames = m_frames + 2'd1;
                        m_fill = 7'd0;
                        ok = 1'b1;
                     end else begin
                        mailbox_shut(REASON_FAULT);
                     end
                  end else if (p == FRAME_BYTES - 1) begin
                     mailbox_shut(REASON_FAULT);
                  end else begin
                     m_fill = 7'(p + 1);
                     ok = 1'b1;
                  end
               end
            end
         end
         OP_CLOSE: begin
            if (r.close_reasons != 3'd0 && hit) begin
               mailbox_shut(r.close_reasons);
               ok = 1'b1;
            end
         end
         OP_QUERY: begin
            ok = hit && m_reasons == 3'd0;
         end
         OP_TAKE: begin
            h = m_head;
            age = r.timestamp - m_time[h];
            if (m_frames != 2'd0 && age > m_timeout)
               mailbox_shut(REASON_FAULT);
            if (m_reasons != 3'd0 && !m_reported) begin
               m_reported = 1'b1;
               res.ok = 1'b1;
               res.kind = KIND_REPORT;
               res.out_generation = m_generation;
               res.out_reasons = m_reasons;
               mailbox_results_q.push_back(res);
               done = 1'b1;
            end else if (m_frames != 2'd0) begin
               for (int i = 0; i < FRAME_BYTES; i++) begin
                  res = '0;
                  res.ok = 1'b1;
                  res.kind = KIND_FRAME;
                  res.out_generation = m_generation;
                  res.out_timestamp = m_time[h];
                  res.out_byte = m_bytes[h * FRAME_BYTES + i];
                  res.last = (i == FRAME_BYTES - 1);
                  mailbox_results_q.push_back(res);
               end
               m_frames = m_frames - 2'd1;
               m_head = ~h;
               done = 1'b1;
            end
         end
         OP_RETIRE: begin
            if (hit && m_reasons != 3'd0 && m_reported) begin
               m_open = 1'b0;
               m_reasons = 3'd0;
               m_reported = 1'b0;
               m_frames = 2'd0;
               m_head = 1'b0;
               m_fill = 7'd0;
               ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!done) begin
         res.ok = ok;
         mailbox_results_q.push_back(res);
      end
   endfunction

   // monitor: predicts on each accepted request, checks each accepted result
   always @(posedge clock) begin : monitor
      rsp_item_type got;
      rsp_item_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            requests_accepted++;
            mailbox_step(req_item);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            got.ok = rsp_tdata[0];
            got.out_generation = rsp_tdata[32:1];
            got.out_timestamp = rsp_tdata[64:33];
            got.out_reasons = rsp_tdata[67:65];
            got.out_byte = rsp_tdata[75:68];
            got.kind = rsp_tuser;
            got.last = rsp_tlast;
            if (mailbox_results_q.size() == 0) begin
               flag_error("result with nothing due, kind", 32'(got.kind), 32'd0);
            end else begin
               want = mailbox_results_q.pop_front();
               if (got.ok !== want.ok)
                  flag_error("ok", 32'(got.ok), 32'(want.ok));
               if (got.kind !== want.kind)
                  flag_error("kind", 32'(got.kind), 32'(want.kind));
               if (got.out_generation !== want.out_generation)
                  flag_error("out_generation", got.out_generation, want.out_generation);
               if (got.out_timestamp !== want.out_timestamp)
                  flag_error("out_timestamp", got.out_timestamp, want.out_timestamp);
               if (got.out_reasons !== want.out_reasons)
                  flag_error("out_reasons", 32'(got.out_reasons), 32'(want.out_reasons));
               if (got.out_byte !== want.out_byte)
                  flag_error("out_byte", 32'(got.out_byte), 32'(want.out_byte));
               if (got.last !== want.last)
                  flag_error("last", 32'(got.last), 32'(want.last));
            end
         end
      end
      if (calm_left > 0)
         calm_left--;
      else if ($urandom_range(0, 499) == 0)
         calm_left = $urandom_range(60, 200);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("generation_mailbox_two_slot_top regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin : req_driver
      logic next_valid;
      req_item_type next_item;
      next_valid = req_tvalid;
      next_item = req_item;
      if (!reset) begin
         if (req_tvalid && req_taken) begin
            next_valid = 1'b0;
            req_gap = idle_length();
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (request_q.size() > 0) begin
               next_item = request_q.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_tvalid <= next_valid;
      req_item <= next_item;
   end

   always @(negedge clock) begin : rsp_driver
      logic next_ready;
      next_ready = 1'b0;
      if (!reset && !rsp_hold) begin
         if (rsp_wait > 0) begin
            rsp_wait--;
         end else begin
            next_ready = 1'b1;
            if (rsp_taken || $urandom_range(0, 15) == 0)
               rsp_wait = idle_length();
         end
      end
      rsp_tready <= next_ready;
   end

   // long receiver hold-off while requests keep coming
   initial begin
      wait (requests_accepted >= 140);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic queue_item(input logic [2:0] op, input logic [31:0] gen, input logic [7:0] data,
                             input logic lastb, input logic [31:0] ts, input logic [2:0] reasons);
      req_item_type it;
      it.opcode = op;
      it.generation = gen;
      it.data_byte = data;
      it.last_byte = lastb;
      it.timestamp = ts;
      it.close_reasons = reasons;
      request_q.push_back(it);
      if (op != OP_SPARE6 && op != OP_SPARE7)
         queued_count++;
   endtask

   task automatic queue_frame(input int n_bytes, input int last_at);
      for (int i = 0; i < n_bytes; i++)
         queue_item(OP_POST, session_gen, 8'($urandom_range(0, 255)), i == last_at,
                    (i == last_at || i == n_bytes - 1) ? clock_now : $urandom,
                    3'($urandom_range(0, 7)));
      clock_now = clock_now + $urandom_range(0, 400);
   endtask

   function automatic logic [31:0] take_age();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(0, 900);
      if (r < 85)
         return $urandom_range(900, 1100);
      if (r < 95)
         return $urandom;
      return 32'd0;
   endfunction

   task automatic queue_take();
      queue_item(OP_TAKE, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 clock_now + take_age(), 3'($urandom_range(0, 7)));
   endtask

   task automatic queue_session();
      int r;
      if ($urandom_range(0, 4) == 0)
         queue_item(OP_OPEN, session_gen, 8'd0, 1'b0, $urandom, 3'd0);
      if ($urandom_range(0, 5) == 0)
         session_gen = session_gen + $urandom_range(1 << 24, 1 << 26);
      else
         session_gen = session_gen + $urandom_range(1, 1 << 16);
      queue_item(OP_OPEN, session_gen, 8'($urandom_range(0, 255)), 1'b0, $urandom, 3'd0);
      repeat ($urandom_range(2, 7)) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            queue_frame(FRAME_BYTES, FRAME_BYTES - 1);
         end else if (r < 60) begin
            queue_take();
         end else if (r < 66) begin
            queue_item(OP_QUERY, session_gen, 8'd0, 1'b0, $urandom, 3'($urandom_range(0, 7)));
         end else if (r < 71) begin
            r = $urandom_range(0, FRAME_BYTES - 2);
            queue_frame(r + 1, r);
         end else if (r < 75) begin
            queue_frame(FRAME_BYTES, -1);
         end else if (r < 80) begin
            queue_item(OP_CLOSE, session_gen, 8'd0, 1'b0, $urandom, 3'($urandom_range(1, 7)));
         end else if (r < 84) begin
            queue_item(OP_CLOSE, session_gen, 8'd0, 1'b0, $urandom, 3'd0);
         end else if (r < 92) begin
            queue_item(3'($urandom_range(1, 7)), $urandom, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)));
         end else begin
            queue_frame(FRAME_BYTES, FRAME_BYTES - 1);
            queue_frame(FRAME_BYTES, FRAME_BYTES - 1);
            queue_frame(3, 2);
         end
      end
      queue_item(OP_CLOSE, session_gen, 8'd0, 1'b0, $urandom, 3'($urandom_range(1, 7)));
      if ($urandom_range(0, 5) == 0)
         queue_item(OP_RETIRE, session_gen, 8'd0, 1'b0, $urandom, 3'd0);
      queue_take();
      queue_take();
      queue_item(OP_RETIRE, session_gen, 8'($urandom_range(0, 255)), 1'b0, $urandom, 3'd0);
   endtask

   task automatic wait_for_drain();
      while (request_q.size() != 0 || req_tvalid || mailbox_results_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      m_timeout = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] phase_timeout [5];
      phase_timeout[0] = 32'd0;
      phase_timeout[1] = 32'hFFFF_FFFF;
      phase_timeout[2] = 32'd1000;
      phase_timeout[3] = $urandom_range(1, 5000);
      phase_timeout[4] = 32'd1;
      clock_now = $urandom;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_item(OP_QUERY, 32'd0, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_POST, 32'd0, 8'hFF, 1'b1, 32'd0, 3'd0);
      queue_item(OP_TAKE, 32'd0, 8'd0, 1'b0, 32'hFFFF_FFFF, 3'd0);
      queue_item(OP_OPEN, 32'd0, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_OPEN, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_OPEN, 32'd2, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_QUERY, 32'd1, 8'd0, 1'b0, 32'hFFFF_FFFF, 3'd7);
      queue_item(OP_QUERY, 32'd2, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_CLOSE, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_CLOSE, 32'd2, 8'd0, 1'b0, 32'd0, 3'd1);
      queue_item(OP_RETIRE, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_SPARE6, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 3'd7);
      queue_item(OP_SPARE7, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_POST, 32'd1, 8'hFF, 1'b0, 32'd0, 3'd0);
      queue_item(OP_POST, 32'd1, 8'h00, 1'b1, 32'hFFFF_FFFF, 3'd0);
      queue_item(OP_POST, 32'd1, 8'h5A, 1'b0, 32'd0, 3'd0);
      queue_item(OP_QUERY, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_TAKE, 32'd0, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_TAKE, 32'd0, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_CLOSE, 32'd1, 8'd0, 1'b0, 32'd0, 3'd3);
      queue_item(OP_TAKE, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_CLOSE, 32'd1, 8'd0, 1'b0, 32'd0, 3'd1);
      queue_item(OP_TAKE, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_RETIRE, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      queue_item(OP_OPEN, 32'd1, 8'd0, 1'b0, 32'd0, 3'd0);
      session_gen = 32'd1;

      for (int phase = 0; phase < 5; phase++) begin
         wait_for_drain();
         write_timeout(phase_timeout[phase]);
         queued_count = 0;
         while (queued_count < PHASE_ITEMS)
            queue_session();
         if (phase == 4) begin
            session_gen = 32'hFFFF_FFFF;
            queue_item(OP_OPEN, session_gen, 8'd0, 1'b0, 32'd0, 3'd0);
            queue_frame(FRAME_BYTES, FRAME_BYTES - 1);
            queue_item(OP_TAKE, 32'd0, 8'd0, 1'b0, clock_now, 3'd0);
            queue_item(OP_OPEN, session_gen, 8'd0, 1'b0, 32'd0, 3'd0);
            queue_item(OP_CLOSE, session_gen, 8'd0, 1'b0, 32'd0, 3'd7);
            queue_item(OP_TAKE, 32'd0, 8'd0, 1'b0, 32'd0, 3'd0);
            queue_item(OP_RETIRE, session_gen, 8'd0, 1'b0, 32'd0, 3'd0);
         end
      end
      wait_for_drain();
      if (error_count == 0)
         $display("generation_mailbox_two_slot_top regression: pass");
      else
         $display("generation_mailbox_two_slot_top regression: fail");
      $finish;
   end

endmodule

@@ generation_mailbox_two_slot_top.f @@
+incdir+src
src/gmts_pkg.sv
src/gmts_ram.sv
src/gmts_out.sv
src/gmts_ctrl.sv
src/generation_mailbox_two_slot_top.sv
verif/tb.sv
